FILE: design/glmf_pkg.sv
// Shared types and constants of the grid local maximum finder.
package glmf_pkg;

	// Width of the running peak ordinal; it wraps at this width.
	localparam int CNT_W = 15;

	// Configuration port geometry.
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	typedef enum logic [1:0] {
		REG_GRID_ROWS = 2'd0,
		REG_GRID_COLS = 2'd1,
		REG_WATCH_ROW = 2'd2,
		REG_WATCH_COL = 2'd3
	} reg_idx_t;

	typedef enum logic {
		KIND_PEAK    = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	// Position class of one queued sample.
	typedef struct packed {
		logic eor;    // last column of its row
		logic eog;    // last sample of the grid
	} glmf_flags_t;

endpackage

FILE: design/glmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module glmf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/glmf_fifo.sv
// Short queue of classified samples between the front and the back.
module glmf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rp_q;
	logic [PW:0]      cnt_q;

	assign full  = (cnt_q == (PW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

FILE: design/glmf_front.sv
// Input side: accepts samples, tracks the raster position and classifies each beat.
module glmf_front import glmf_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int RIDX_W      = 10,
	parameter int CIDX_W      = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   restart,
	input  logic [RIDX_W-1:0]      last_row,
	input  logic [CIDX_W-1:0]      last_col,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   fifo_full,
	output logic                   push,
	output logic [SAMPLE_BITS-1:0] push_sample,
	output logic [RIDX_W-1:0]      push_row,
	output logic [CIDX_W-1:0]      push_col,
	output glmf_flags_t            push_flags
);

	logic [RIDX_W-1:0] row_q;
	logic [CIDX_W-1:0] col_q;

	assign in_ready         = !fifo_full;
	assign push             = in_valid && in_ready;
	assign push_sample      = sample;
	assign push_row         = row_q;
	assign push_col         = col_q;
	assign push_flags.eor   = (col_q == last_col);
	assign push_flags.eog   = (col_q == last_col) && (row_q == last_row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (restart) begin
			row_q <= '0;
			col_q <= '0;
		end else if (push) begin
			if (push_flags.eor) begin
				col_q <= '0;
				row_q <= push_flags.eog ? '0 : row_q + RIDX_W'(1);
			end else begin
				col_q <= col_q + CIDX_W'(1);
			end
		end
	end

endmodule

FILE: design/glmf_back.sv
// Work side: line buffers, 3x3 window, peak judging, last-row flush and result register.
module glmf_back import glmf_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_COLS    = 64,
	parameter int RIDX_W      = 10,
	parameter int CIDX_W      = 6,
	parameter int ROW_W       = 11,
	parameter int COL_W       = 7
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   restart,
	input  logic [CIDX_W-1:0]      last_col,
	input  logic [ROW_W-1:0]       watch_row,
	input  logic [COL_W-1:0]       watch_col,
	input  logic                   fifo_empty,
	output logic                   fifo_pop,
	input  logic [SAMPLE_BITS-1:0] hd_sample,
	input  logic [RIDX_W-1:0]      hd_row,
	input  logic [CIDX_W-1:0]      hd_col,
	input  glmf_flags_t            hd_flags,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   kind,
	output logic [ROW_W-1:0]       peak_row,
	output logic [COL_W-1:0]       peak_col,
	output logic [CNT_W-1:0]       peak_count,
	output logic                   watch_hit,
	output logic                   last
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_JUDGE,
		S_FREAD,
		S_FLOAD,
		S_SUM
	} state_t;

	state_t            state_q;
	logic [RIDX_W-1:0] row_q;
	logic [CIDX_W-1:0] col_q;
	glmf_flags_t       flags_q;
	logic              flush_q;
	logic              sel_q;
	logic [1:0]        role_q;
	logic [CNT_W-1:0]  peaks_q;
	logic              watch_q;

	logic              out_valid_q;
	logic              kind_q;
	logic [ROW_W-1:0]  row_out_q;
	logic [COL_W-1:0]  col_out_q;
	logic [CNT_W-1:0]  count_out_q;
	logic              hit_out_q;
	logic              last_out_q;

	logic signed [SAMPLE_BITS-1:0] top_q [3];
	logic signed [SAMPLE_BITS-1:0] mid_q [3];
	logic signed [SAMPLE_BITS-1:0] bot_q [3];
	logic [1:0]                    colok_q;
	logic [SAMPLE_BITS-1:0]        smp_q;

	logic [SAMPLE_BITS-1:0] rd_data [3];
	logic [2:0]             ram_we;
	logic [CIDX_W-1:0]      rd_addr;
	logic [1:0]             up_i;
	logic [1:0]             mid_i;
	logic [1:0]             next_role;

	logic signed [SAMPLE_BITS-1:0] new_top;
	logic signed [SAMPLE_BITS-1:0] new_mid;
	logic signed [SAMPLE_BITS-1:0] new_bot;

	logic                          rows_on;
	logic                          need_a;
	logic                          need_b;
	logic                          top_ok;
	logic                          bot_ok;
	logic [1:0]                    lc;
	logic [1:0]                    cc;
	logic signed [SAMPLE_BITS-1:0] v;
	logic                          left_hit;
	logic                          ctr_hit;
	logic                          right_hit;
	logic                          peak_now;
	logic [ROW_W-1:0]              cell_row1;
	logic [COL_W-1:0]              cell_col1;
	logic                          out_free;
	logic                          out_load;

	assign fifo_pop = (state_q == S_IDLE) && !fifo_empty;
	assign rd_addr  = (state_q == S_IDLE) ? hd_col : col_q;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = ((state_q == S_JUDGE) && peak_now && out_free)
	                  || ((state_q == S_SUM) && out_free);

	// Line roles rotate: role_q is the receiving line, the one before it the middle row.
	always_comb begin
		unique case (role_q)
			2'd0: begin
				mid_i = 2'd2;
				up_i  = 2'd1;
			end
			2'd1: begin
				mid_i = 2'd0;
				up_i  = 2'd2;
			end
			2'd2: begin
				mid_i = 2'd1;
				up_i  = 2'd0;
			end
			default: begin
				mid_i = 2'd0;
				up_i  = 2'd0;
			end
		endcase
	end

	assign next_role = (role_q == 2'd2) ? 2'd0 : role_q + 2'd1;

	for (genvar i = 0; i < 3; i++) begin : g_line
		assign ram_we[i] = fifo_pop && (role_q == 2'(i));
		glmf_ram #(
			.WIDTH(SAMPLE_BITS),
			.DEPTH(MAX_COLS)
		) u_line (
			.clk  (clk),
			.we   (ram_we[i]),
			.waddr(hd_col),
			.wdata(hd_sample),
			.raddr(rd_addr),
			.rdata(rd_data[i])
		);
	end

	// Flush pass: middle line is the row above, receiving line the judged row.
	always_comb begin
		if (flush_q) begin
			new_top = rd_data[mid_i];
			new_mid = rd_data[role_q];
		end else begin
			new_top = rd_data[up_i];
			new_mid = rd_data[mid_i];
		end
		new_bot = smp_q;
	end

	always_comb begin
		rows_on   = flush_q || (row_q != '0);
		need_a    = rows_on && (col_q != '0);
		need_b    = rows_on && (col_q == last_col);
		top_ok    = flush_q ? (row_q != '0) : (row_q > RIDX_W'(1));
		bot_ok    = !flush_q;
		lc        = {1'b0, sel_q};
		cc        = sel_q ? 2'd2 : 2'd1;
		v         = mid_q[cc];
		left_hit  = colok_q[sel_q] && ((top_ok && top_q[lc] >= v) || mid_q[lc] >= v
		            || (bot_ok && bot_q[lc] >= v));
		ctr_hit   = (top_ok && top_q[cc] >= v) || (bot_ok && bot_q[cc] >= v);
		right_hit = !sel_q && ((top_ok && top_q[2] >= v) || mid_q[2] >= v
		            || (bot_ok && bot_q[2] >= v));
		peak_now  = (sel_q ? need_b : need_a) && !left_hit && !ctr_hit && !right_hit;
		cell_row1 = ROW_W'(row_q) + ROW_W'(flush_q);
		cell_col1 = COL_W'(col_q) + COL_W'(sel_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			flags_q     <= '0;
			flush_q     <= 1'b0;
			sel_q       <= 1'b0;
			role_q      <= 2'd0;
			peaks_q     <= '0;
			watch_q     <= 1'b0;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_PEAK;
			row_out_q   <= '0;
			col_out_q   <= '0;
			count_out_q <= '0;
			hit_out_q   <= 1'b0;
			last_out_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (fifo_pop) begin
						row_q   <= hd_row;
						col_q   <= hd_col;
						flags_q <= hd_flags;
						state_q <= S_LOAD;
					end
				end
				S_LOAD, S_FLOAD: begin
					sel_q   <= 1'b0;
					state_q <= S_JUDGE;
				end
				S_FREAD: begin
					state_q <= S_FLOAD;
				end
				S_JUDGE: begin
					// Hold while a peak waits for the result register.
					if (!peak_now || out_free) begin
						if (peak_now) begin
							kind_q      <= KIND_PEAK;
							row_out_q   <= cell_row1;
							col_out_q   <= cell_col1;
							count_out_q <= peaks_q + CNT_W'(1);
							hit_out_q   <= 1'b0;
							last_out_q  <= 1'b0;
							peaks_q     <= peaks_q + CNT_W'(1);
							if (cell_row1 == watch_row && cell_col1 == watch_col) begin
								watch_q <= 1'b1;
							end
						end
						if (!sel_q && need_b) begin
							sel_q <= 1'b1;
						end else begin
							sel_q <= 1'b0;
							priority if (flush_q) begin
								if (col_q == last_col) begin
									state_q <= S_SUM;
								end else begin
									col_q   <= col_q + CIDX_W'(1);
									state_q <= S_FREAD;
								end
							end else if (flags_q.eog) begin
								flush_q <= 1'b1;
								col_q   <= '0;
								state_q <= S_FREAD;
							end else begin
								if (flags_q.eor) begin
									role_q <= next_role;
								end
								state_q <= S_IDLE;
							end
						end
					end
				end
				S_SUM: begin
					if (out_free) begin
						kind_q      <= KIND_SUMMARY;
						row_out_q   <= '0;
						col_out_q   <= '0;
						count_out_q <= peaks_q;
						hit_out_q   <= watch_q;
						last_out_q  <= 1'b1;
						peaks_q     <= '0;
						watch_q     <= 1'b0;
						flush_q     <= 1'b0;
						role_q      <= next_role;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (restart) begin
				peaks_q <= '0;
				watch_q <= 1'b0;
			end
		end
	end

	// Window shift: column 2 is the newest, column 0 the oldest.
	always_ff @(posedge clk) begin
		if (fifo_pop) begin
			smp_q <= hd_sample;
		end
		if (state_q == S_LOAD || state_q == S_FLOAD) begin
			top_q[0]   <= top_q[1];
			top_q[1]   <= top_q[2];
			top_q[2]   <= new_top;
			mid_q[0]   <= mid_q[1];
			mid_q[1]   <= mid_q[2];
			mid_q[2]   <= new_mid;
			bot_q[0]   <= bot_q[1];
			bot_q[1]   <= bot_q[2];
			bot_q[2]   <= new_bot;
			colok_q[0] <= colok_q[1] && (col_q != '0);
			colok_q[1] <= (col_q != '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign peak_row   = row_out_q;
	assign peak_col   = col_out_q;
	assign peak_count = count_out_q;
	assign watch_hit  = hit_out_q;
	assign last       = last_out_q;

endmodule

FILE: design/grid_strict_local_max_finder.sv
// Top level of the grid strict local maximum finder: config registers, front, queue, back.
//
//  channel  direction  handshake                 payload
//  in       input      in_valid / in_ready       sample
//  out      output     out_valid / out_ready     kind, peak_row, peak_col, peak_count,
//                                                watch_hit, last
//  cfg      input      psel / penable / pwrite   paddr, pwdata, prdata (pready tied high)
//
// For each sample the back pops the queue with a line read, loads the window and uses a
// judge slot, with a second judge slot at the end of each row below the first; each peak
// waits while the result register is held.
// The last sample adds a flush of the last row (line read, window load, judge per column),
// then the summary. A 4-beat queue lets the input keep accepting while the back works.
// Reset needs no clearing pass; line buffers are read only where written this grid.
// Any configuration write restarts the grid.
module grid_strict_local_max_finder import glmf_pkg::*; #(
	parameter int MAX_COLS    = 64,
	parameter int MAX_ROWS    = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   kind,
	output logic [$clog2(MAX_ROWS+1)-1:0] peak_row,
	output logic [$clog2(MAX_COLS+1)-1:0] peak_col,
	output logic [CNT_W-1:0]       peak_count,
	output logic                   watch_hit,
	output logic                   last,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_AW-1:0]      paddr,
	input  logic [APB_DW-1:0]      pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	localparam int ROW_W   = $clog2(MAX_ROWS + 1);
	localparam int COL_W   = $clog2(MAX_COLS + 1);
	localparam int RIDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CIDX_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int Q_DEPTH = 4;
	localparam int QW      = SAMPLE_BITS + RIDX_W + CIDX_W + $bits(glmf_flags_t);

	logic [ROW_W-1:0]  grid_rows_q;
	logic [COL_W-1:0]  grid_cols_q;
	logic [ROW_W-1:0]  watch_row_q;
	logic [COL_W-1:0]  watch_col_q;
	logic              cfg_we;
	reg_idx_t          cfg_idx;
	logic [ROW_W-1:0]  rows_c;
	logic [COL_W-1:0]  cols_c;
	logic [RIDX_W-1:0] last_row;
	logic [CIDX_W-1:0] last_col;

	logic                   fifo_push;
	logic                   fifo_pop;
	logic                   fifo_full;
	logic                   fifo_empty;
	logic [QW-1:0]          fifo_wdata;
	logic [QW-1:0]          fifo_rdata;
	logic [SAMPLE_BITS-1:0] push_sample;
	logic [RIDX_W-1:0]      push_row;
	logic [CIDX_W-1:0]      push_col;
	glmf_flags_t            push_flags;
	logic [SAMPLE_BITS-1:0] hd_sample;
	logic [RIDX_W-1:0]      hd_row;
	logic [CIDX_W-1:0]      hd_col;
	glmf_flags_t            hd_flags;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= ROW_W'(1);
			grid_cols_q <= COL_W'(1);
			watch_row_q <= ROW_W'(1);
			watch_col_q <= COL_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_GRID_ROWS: grid_rows_q <= pwdata[ROW_W-1:0];
				REG_GRID_COLS: grid_cols_q <= pwdata[COL_W-1:0];
				REG_WATCH_ROW: watch_row_q <= pwdata[ROW_W-1:0];
				REG_WATCH_COL: watch_col_q <= pwdata[COL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_GRID_ROWS: prdata = APB_DW'(grid_rows_q);
			REG_GRID_COLS: prdata = APB_DW'(grid_cols_q);
			REG_WATCH_ROW: prdata = APB_DW'(watch_row_q);
			REG_WATCH_COL: prdata = APB_DW'(watch_col_q);
			default:       prdata = '0;
		endcase
	end

	// Saturate the grid size to the supported range.
	always_comb begin
		priority if (grid_rows_q == '0) begin
			rows_c = ROW_W'(1);
		end else if (grid_rows_q > ROW_W'(MAX_ROWS)) begin
			rows_c = ROW_W'(MAX_ROWS);
		end else begin
			rows_c = grid_rows_q;
		end
		priority if (grid_cols_q == '0) begin
			cols_c = COL_W'(1);
		end else if (grid_cols_q > COL_W'(MAX_COLS)) begin
			cols_c = COL_W'(MAX_COLS);
		end else begin
			cols_c = grid_cols_q;
		end
	end

	assign last_row = RIDX_W'(rows_c - ROW_W'(1));
	assign last_col = CIDX_W'(cols_c - COL_W'(1));

	glmf_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.RIDX_W     (RIDX_W),
		.CIDX_W     (CIDX_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (cfg_we),
		.last_row   (last_row),
		.last_col   (last_col),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.fifo_full  (fifo_full),
		.push       (fifo_push),
		.push_sample(push_sample),
		.push_row   (push_row),
		.push_col   (push_col),
		.push_flags (push_flags)
	);

	assign fifo_wdata = {push_sample, push_row, push_col, push_flags};
	assign {hd_sample, hd_row, hd_col, hd_flags} = fifo_rdata;

	glmf_fifo #(
		.WIDTH(QW),
		.DEPTH(Q_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fifo_push),
		.wdata (fifo_wdata),
		.pop   (fifo_pop),
		.rdata (fifo_rdata),
		.full  (fifo_full),
		.empty (fifo_empty)
	);

	glmf_back #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.MAX_COLS   (MAX_COLS),
		.RIDX_W     (RIDX_W),
		.CIDX_W     (CIDX_W),
		.ROW_W      (ROW_W),
		.COL_W      (COL_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (cfg_we),
		.last_col  (last_col),
		.watch_row (watch_row_q),
		.watch_col (watch_col_q),
		.fifo_empty(fifo_empty),
		.fifo_pop  (fifo_pop),
		.hd_sample (hd_sample),
		.hd_row    (hd_row),
		.hd_col    (hd_col),
		.hd_flags  (hd_flags),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.peak_row  (peak_row),
		.peak_col  (peak_col),
		.peak_count(peak_count),
		.watch_hit (watch_hit),
		.last      (last)
	);

`ifndef SYNTHESIS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_pop |-> !fifo_empty)
		else $error("queue popped while empty");

	a_summary_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind) |-> (last && peak_row == '0 && peak_col == '0))
		else $error("summary beat malformed");

	a_report_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !kind) |-> (!last && !watch_hit && peak_row != '0 && peak_col != '0))
		else $error("peak report beat malformed");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_full && !fifo_pop) |=> !fifo_empty)
		else $error("queue lost entries");
`endif

endmodule
